[src/pdx_pkg.sv]
// Package: shared types, constants and pixel functions of the depth expander.
`timescale 1ns / 1ps
package pdx_pkg;

	localparam int SRC_W       = 16;
	localparam int DEST_W      = 64;
	localparam int PIX_W       = 8;
	localparam int LINE_W      = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int MODE_W      = 3;
	localparam int OP_W        = 3;
	localparam int LANE_W      = 3;
	localparam int QDEPTH      = 2;
	localparam int QCNT_W      = 2;

	localparam logic [LINE_W-1:0] MAX_LINE_PIXELS = LINE_W'(4096);
	localparam logic [LINE_W-1:0] LINE_RESET      = LINE_W'(640);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_OP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_PIXELS = 2'd2;

	// Depth codes
	localparam logic [MODE_W-1:0] DEPTH_1BIT  = 3'd0;
	localparam logic [MODE_W-1:0] DEPTH_2BIT  = 3'd1;
	localparam logic [MODE_W-1:0] DEPTH_4BIT  = 3'd2;
	localparam logic [MODE_W-1:0] DEPTH_8BIT  = 3'd3;
	localparam logic [MODE_W-1:0] DEPTH_RGB16 = 3'd4;
	localparam logic [MODE_W-1:0] DEPTH_RESET = DEPTH_8BIT;

	// Transfer operation codes
	localparam logic [OP_W-1:0] OP_COPY    = 3'd0;
	localparam logic [OP_W-1:0] OP_OR      = 3'd1;
	localparam logic [OP_W-1:0] OP_XOR     = 3'd2;
	localparam logic [OP_W-1:0] OP_ANDNOT  = 3'd3;
	localparam logic [OP_W-1:0] OP_NOT     = 3'd4;
	localparam logic [OP_W-1:0] OP_ORNOT   = 3'd5;
	localparam logic [OP_W-1:0] OP_XORNOT  = 3'd6;
	localparam logic [OP_W-1:0] OP_AND     = 3'd7;

	// Log2 of pixel width in the indexed modes
	typedef enum logic [1:0] {
		LOG_1BIT = 2'd0,
		LOG_2BIT = 2'd1,
		LOG_4BIT = 2'd2,
		LOG_8BIT = 2'd3
	} pix_log_t;

	// Classified word handed from front to back
	typedef struct packed {
		logic [SRC_W-1:0]  word;
		logic [DEST_W-1:0] dest;
		logic              rgb;
		pix_log_t          plog;
		logic [OP_W-1:0]   op;
	} job_t;

	// Line length control from the register file to the back end
	typedef struct packed {
		logic              reload;
		logic [LINE_W-1:0] len;
	} line_ctl_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} queue_stat_t;

	typedef struct packed {
		logic [LINE_W-1:0] pixels_left;
	} back_stat_t;

	// Clamp a written line length to 1..MAX_LINE_PIXELS
	function automatic logic [LINE_W-1:0] line_length(input logic [CFG_DATA_W-1:0] n);
		logic [LINE_W-1:0] r;
		r = LINE_W'(n);
		if (r == '0)
			r = LINE_W'(1);
		else if (r > MAX_LINE_PIXELS)
			r = MAX_LINE_PIXELS;
		return r;
	endfunction

	// Raster transfer of source pixel s onto destination byte d
	function automatic logic [PIX_W-1:0] merge(input logic [OP_W-1:0] op,
		input logic [PIX_W-1:0] s, input logic [PIX_W-1:0] d);
		logic [PIX_W-1:0] r;
		case (op)
			OP_OR:     r = d | s;
			OP_XOR:    r = d ^ s;
			OP_ANDNOT: r = d & ~s;
			OP_NOT:    r = ~s;
			OP_ORNOT:  r = d | ~s;
			OP_XORNOT: r = d ^ ~s;
			OP_AND:    r = d & s;
			default:   r = s;
		endcase
		return r;
	endfunction

	// Widen a 5-bit component by copying its top bits into the low bits
	function automatic logic [PIX_W-1:0] widen5(input logic [4:0] c);
		return {c, c[4:2]};
	endfunction

endpackage

[src/pdx_if.sv]
// Interfaces: source word, pixel result and configuration write channels.
`timescale 1ns / 1ps
interface pdx_in_if;
	logic                         valid;
	logic                         ready;
	logic [pdx_pkg::SRC_W-1:0]    source_word;
	logic [pdx_pkg::DEST_W-1:0]   dest_pixels;

	modport source (output valid, source_word, dest_pixels, input ready);
	modport sink   (input valid, source_word, dest_pixels, output ready);
endinterface

interface pdx_out_if;
	logic                         valid;
	logic                         ready;
	logic [pdx_pkg::PIX_W-1:0]    pixel_index;
	logic [pdx_pkg::PIX_W-1:0]    red;
	logic [pdx_pkg::PIX_W-1:0]    green;
	logic [pdx_pkg::PIX_W-1:0]    blue;
	logic                         end_of_line;
	logic                         last;

	modport source (output valid, pixel_index, red, green, blue, end_of_line, last,
		input ready);
	modport sink   (input valid, pixel_index, red, green, blue, end_of_line, last,
		output ready);
endinterface

interface pdx_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pdx_pkg::CFG_IDX_W-1:0]  index;
	logic [pdx_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[src/pdx_front.sv]
// Front end: register file, input transfer and word classification.
`timescale 1ns / 1ps
module pdx_front (
	input  logic                 clk,
	input  logic                 arst_n,
	pdx_in_if.sink               pix_in,
	pdx_cfg_if.sink              cfg,
	input  logic                 q_full,
	output logic                 push,
	output pdx_pkg::job_t        push_job,
	output pdx_pkg::line_ctl_t   line_ctl
);
	import pdx_pkg::*;

	logic [MODE_W-1:0] depth_mode_q;
	logic [OP_W-1:0]   transfer_op_q;
	logic [LINE_W-1:0] line_len_q;
	logic              cfg_wr;

	// Register writes are always taken
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q  <= DEPTH_RESET;
			transfer_op_q <= OP_COPY;
			line_len_q    <= LINE_RESET;
		end else if (cfg_wr) begin
			case (cfg.index)
				REG_DEPTH_MODE:  depth_mode_q  <= cfg.data[MODE_W-1:0];
				REG_TRANSFER_OP: transfer_op_q <= cfg.data[OP_W-1:0];
				REG_LINE_PIXELS: line_len_q    <= line_length(cfg.data);
				default: ;
			endcase
		end
	end

	// A line length write restarts the line in the back end
	assign line_ctl.reload = cfg_wr && (cfg.index == REG_LINE_PIXELS);
	assign line_ctl.len    = line_length(cfg.data);

	// Accept a word whenever the queue has room
	assign pix_in.ready = !q_full;
	assign push         = pix_in.valid && pix_in.ready;

	// Classify the word by depth; unused codes and rgb run as one 8-bit lane
	always_comb begin
		push_job.word = pix_in.source_word;
		push_job.dest = pix_in.dest_pixels;
		push_job.op   = transfer_op_q;
		push_job.rgb  = 1'b0;
		case (depth_mode_q)
			DEPTH_1BIT:  push_job.plog = LOG_1BIT;
			DEPTH_2BIT:  push_job.plog = LOG_2BIT;
			DEPTH_4BIT:  push_job.plog = LOG_4BIT;
			DEPTH_RGB16: begin
				push_job.plog = LOG_8BIT;
				push_job.rgb  = 1'b1;
			end
			default:     push_job.plog = LOG_8BIT;
		endcase
	end

endmodule

[src/pdx_queue.sv]
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
module pdx_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pdx_pkg::job_t         push_job,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output pdx_pkg::job_t         head,
	output pdx_pkg::queue_stat_t  stat
);
	import pdx_pkg::*;

	job_t              entry_q [QDEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign stat.count = count_q;

	// Store payload on push
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

[src/pdx_back.sv]
// Back end: pixel sequencer, line counter and output register.
`timescale 1ns / 1ps
module pdx_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  pdx_pkg::job_t        head,
	output logic                 pop,
	input  pdx_pkg::line_ctl_t   line_ctl,
	pdx_out_if.source            pix_out,
	output pdx_pkg::back_stat_t  stat
);
	import pdx_pkg::*;

	logic [LANE_W-1:0] lane_q;
	logic [LINE_W-1:0] pixels_left_q;
	logic [LINE_W-1:0] line_len_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  pixel_index_q;
	logic [PIX_W-1:0]  red_q;
	logic [PIX_W-1:0]  green_q;
	logic [PIX_W-1:0]  blue_q;
	logic              eol_q;
	logic              last_q;

	logic              advance;
	logic              fire;
	logic              eol;
	logic              lane_last;
	logic              is_last;
	logic [LANE_W-1:0] last_lane;
	logic [PIX_W-1:0]  shifted;
	logic [PIX_W-1:0]  src_pix;
	logic [PIX_W-1:0]  dst_pix;

	assign advance = !out_valid_q || pix_out.ready;
	assign fire    = head_valid && advance;
	assign eol     = (pixels_left_q == LINE_W'(1));

	// Pick the lane's source bits, leftmost pixel first
	always_comb begin
		shifted = head.word[PIX_W-1:0] << (lane_q << head.plog);
		case (head.plog)
			LOG_1BIT: begin
				src_pix   = {7'd0, shifted[7]};
				last_lane = 3'd7;
			end
			LOG_2BIT: begin
				src_pix   = {6'd0, shifted[7:6]};
				last_lane = 3'd3;
			end
			LOG_4BIT: begin
				src_pix   = {4'd0, shifted[7:4]};
				last_lane = 3'd1;
			end
			default: begin
				src_pix   = shifted;
				last_lane = 3'd0;
			end
		endcase
	end

	assign dst_pix   = head.dest[{lane_q, 3'b000} +: PIX_W];
	assign lane_last = (lane_q == last_lane);
	assign is_last   = eol || lane_last;
	assign pop       = fire && is_last;

	// Step through the lanes of the head word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lane_q <= '0;
		else if (fire)
			lane_q <= is_last ? '0 : lane_q + LANE_W'(1);
	end

	// Count down the line; reload on a length write or at end of line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_left_q <= LINE_RESET;
			line_len_q    <= LINE_RESET;
		end else if (line_ctl.reload) begin
			pixels_left_q <= line_ctl.len;
			line_len_q    <= line_ctl.len;
		end else if (fire) begin
			pixels_left_q <= eol ? line_len_q : pixels_left_q - LINE_W'(1);
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pixel_index_q <= head.rgb ? '0 : merge(head.op, src_pix, dst_pix);
			red_q         <= head.rgb ? widen5(head.word[14:10]) : '0;
			green_q       <= head.rgb ? widen5(head.word[9:5]) : '0;
			blue_q        <= head.rgb ? widen5(head.word[4:0]) : '0;
			eol_q         <= eol;
			last_q        <= is_last;
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.pixel_index = pixel_index_q;
	assign pix_out.red         = red_q;
	assign pix_out.green       = green_q;
	assign pix_out.blue        = blue_q;
	assign pix_out.end_of_line = eol_q;
	assign pix_out.last        = last_q;
	assign stat.pixels_left    = pixels_left_q;

endmodule

[src/pixel_depth_expand_raster_op_top.sv]
// Top level: packed pixel depth expander with raster transfer operation.
// A word passes the queue entry, then its pixels pass the output register.
// Throughput: one pixel per cycle while the sink is ready; the lane sequencer
// makes 8, 4, 2 or 1 pixels per word (1, 2, 4, 8-bit, rgb), fewer at line end.
// A two-entry queue lets the next word transfer while the current one drains.
// Reset (arst_n low) loads depth 8-bit, copy, 640-pixel line; queue empty.
`timescale 1ns / 1ps
module pixel_depth_expand_raster_op_top (
	input  logic       clk,
	input  logic       arst_n,
	pdx_in_if.sink     pix_in,
	pdx_out_if.source  pix_out,
	pdx_cfg_if.sink    cfg
);
	import pdx_pkg::*;

	logic        push;
	job_t        push_job;
	logic        q_full;
	logic        pop;
	logic        head_valid;
	job_t        head;
	line_ctl_t   line_ctl;
	queue_stat_t q_stat;
	back_stat_t  b_stat;

	pdx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job),
		.line_ctl (line_ctl)
	);

	pdx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.stat       (q_stat)
	);

	pdx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.line_ctl   (line_ctl),
		.pix_out    (pix_out),
		.stat       (b_stat)
	);

	// End of line always closes the word's results
	a_eol_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.end_of_line |-> pix_out.last)
		else $error("end_of_line without last");

	// Queue never overflows or pops when empty
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.count <= QCNT_W'(QDEPTH)) && !(pop && q_stat.count == '0))
		else $error("queue occupancy out of range");

	// Line counter stays within 1..MAX_LINE_PIXELS
	a_line_count: assert property (@(posedge clk) disable iff (!arst_n)
		(b_stat.pixels_left != '0) && (b_stat.pixels_left <= MAX_LINE_PIXELS))
		else $error("pixels_left out of range");

	// A line end reloads the counter on the next cycle unless a write intervenes
	a_eol_reload: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_valid && (b_stat.pixels_left == LINE_W'(1)) && !line_ctl.reload
		|=> b_stat.pixels_left != '0)
		else $error("line counter not reloaded at end of line");

endmodule
